>>> rtl/lmb_pkg.sv
package lmb_pkg;

   localparam int COL_IDX_BITS   = 12;
   localparam int CFG_COLS_BITS  = 13;
   localparam int CFG_ROWS_BITS  = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CFG_COLS_BITS-1:0] COLS_RESET = 13'd2048;
   localparam logic [CFG_ROWS_BITS-1:0] ROWS_RESET = 16'd2048;

   // result queue geometry
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = 3;
   localparam int FIFO_CNT_BITS = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_ROW_COUNT    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                    binary_value;
      logic [COL_IDX_BITS-1:0] column_index;
      logic                    row_end;
      logic                    frame_end;
   } rsp_entry_type;

endpackage

>>> rtl/local_mean_binarize_3x3.sv
// Path: results caused by a transaction go through the stage 1 register (line buffer read),
//    the stage 2 register (window threshold) and the result queue to the rsp_ ports.
// Throughput: one req_ transaction per cycle unless req_ready is low; each gives at most one
//    result but the last column of a row gives two, so an 8-entry queue absorbs the extra one.
// Reset (synchronous, active high): register defaults, positions, window and queue cleared;
//    the line buffers are not cleared and are always written before they are read.
module local_mean_binarize_3x3
   import lmb_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096,
   parameter int PIXEL_BITS  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_binary_value,
   output logic [COL_IDX_BITS-1:0]   rsp_column_index,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end,
   // configuration writes
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int CW       = $clog2(MAX_COLUMNS);
   localparam int EW       = (CW + 1 > CFG_COLS_BITS) ? CW + 1 : CFG_COLS_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 4;
   localparam int NEED_BITS = FIFO_CNT_BITS + 1;

   // one window column, rows top (0) to bottom (2)
   typedef logic [2:0][PIXEL_BITS-1:0] column_type;

   // 1 when nine times the centre exceeds the sum of the nine pixels
   function automatic logic threshold(input column_type l, input column_type m,
                                      input column_type r);
      logic [SUM_BITS-1:0] sum;
      logic [SUM_BITS-1:0] nine_c;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         sum = sum + SUM_BITS'(l[i]) + SUM_BITS'(m[i]) + SUM_BITS'(r[i]);
      end
      nine_c = (SUM_BITS'(m[1]) << 3) + SUM_BITS'(m[1]);
      return nine_c > sum;
   endfunction

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [CFG_COLS_BITS-1:0] column_count_ff;
   logic [CFG_ROWS_BITS-1:0] row_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLS_RESET;
         row_count_ff    <= ROWS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata[CFG_COLS_BITS-1:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[CFG_ROWS_BITS-1:0];
            default:          ;
         endcase
      end
   end

   // Effective geometry: zero columns act as one, too many act as MAX_COLUMNS;
   // zero rows act as one.
   logic [EW-1:0]            cols_ext;
   logic [EW-1:0]            eff_cols;
   logic [CW-1:0]            last_col;
   logic [CFG_ROWS_BITS-1:0] eff_rows;

   always_comb begin
      cols_ext = EW'(column_count_ff);
      if (cols_ext == '0) begin
         eff_cols = EW'(1);
      end else if (cols_ext > EW'(MAX_COLUMNS)) begin
         eff_cols = EW'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_ext;
      end
      last_col = CW'(eff_cols - EW'(1));
      eff_rows = (row_count_ff == '0) ? CFG_ROWS_BITS'(1) : row_count_ff;
   end

   // ---------------------------------------------------------------------------------
   // Intake: raster position and the decision whether a transaction does any work.
   // row_pos_ff equal to the row count means the drain row.
   // ---------------------------------------------------------------------------------
   logic                     accept;
   logic                     act;
   logic                     at_last;
   logic [CW-1:0]            col_pos_ff, col_pos_in;
   logic [CFG_ROWS_BITS-1:0] row_pos_ff, row_pos_in;

   assign accept  = req_valid & req_ready;
   assign at_last = (col_pos_ff == last_col);
   // drain ticks only count once the frame is in; pixels are dropped while draining
   assign act     = req_opcode ? (row_pos_ff == eff_rows) : (row_pos_ff < eff_rows);

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (accept && act) begin
         if (at_last) begin
            col_pos_in = '0;
            row_pos_in = req_opcode ? '0 : row_pos_ff + CFG_ROWS_BITS'(1);
         end else begin
            col_pos_in = col_pos_ff + CW'(1);
         end
      end
   end

   // any configuration write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // Stage 1 register: the transaction while its line buffer read completes
   logic                  s1_valid_ff;
   logic                  s1_act_ff;
   logic                  s1_drain_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [CW-1:0]         s1_col_ff;
   logic                  s1_first_ff;
   logic                  s1_c0_ff;
   logic                  s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_act_ff   <= act;
      s1_drain_ff <= req_opcode;
      s1_pix_ff   <= req_pixel;
      s1_col_ff   <= col_pos_ff;
      s1_first_ff <= (row_pos_ff == '0);
      s1_c0_ff    <= (col_pos_ff == '0);
      s1_last_ff  <= at_last;
   end

   // ---------------------------------------------------------------------------------
   // Line buffers: upper holds the row above the one being finished, middle the row
   // being finished. Read at intake, written in the following cycle at stage 1.
   // ---------------------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] upper_mem  [MAX_COLUMNS];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_COLUMNS];
   logic [PIXEL_BITS-1:0] upper_rd_ff, middle_rd_ff;
   logic                  byp_ff;
   logic [PIXEL_BITS-1:0] byp_upper_ff, byp_middle_ff;

   logic                  s1_work;
   logic                  wr_en;
   logic [PIXEL_BITS-1:0] upper_q, middle_q;
   logic [PIXEL_BITS-1:0] top, mid, bot;

   assign s1_work  = s1_valid_ff & s1_act_ff;
   // forward a write that lands in the same cycle as the read of that column
   assign upper_q  = byp_ff ? byp_upper_ff  : upper_rd_ff;
   assign middle_q = byp_ff ? byp_middle_ff : middle_rd_ff;
   // drain ticks replicate the last row as the bottom row
   assign bot      = s1_drain_ff ? middle_q : s1_pix_ff;
   // the top row replicates itself upwards
   assign top      = s1_first_ff ? bot : upper_q;
   assign mid      = s1_first_ff ? bot : middle_q;
   // drain ticks leave the buffers as they are
   assign wr_en    = s1_work & (s1_first_ff | ~s1_drain_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[s1_col_ff]  <= mid;
         middle_mem[s1_col_ff] <= bot;
      end
      upper_rd_ff  <= upper_mem[col_pos_ff];
      middle_rd_ff <= middle_mem[col_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr_en && (s1_col_ff == col_pos_ff);
      end
      byp_upper_ff  <= mid;
      byp_middle_ff <= bot;
   end

   // ---------------------------------------------------------------------------------
   // Window: three columns, left (0) to right (2). The first column of a row fills
   // all three (left replication); the last column is shifted in twice (right
   // replication). left_ff keeps the left column from before the second shift so the
   // result for the penultimate column can still be formed.
   // ---------------------------------------------------------------------------------
   column_type win_ff [3];
   column_type win_in [3];
   column_type step1  [3];
   column_type left_ff, left_in;
   column_type new_col;

   always_comb begin
      new_col = {bot, mid, top};
      if (s1_c0_ff) begin
         step1[0] = new_col;
         step1[1] = new_col;
      end else begin
         step1[0] = win_ff[1];
         step1[1] = win_ff[2];
      end
      step1[2] = new_col;

      win_in  = win_ff;
      left_in = left_ff;
      if (s1_work) begin
         left_in = step1[0];
         if (s1_last_ff) begin
            win_in[0] = step1[1];
            win_in[1] = step1[2];
            win_in[2] = new_col;
         end else begin
            win_in = step1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         win_ff <= win_in;
      end
      left_ff <= left_in;
   end

   // Stage 2 register: which results this transaction releases
   logic          s2_e1_ff;
   logic          s2_e2_ff;
   logic          s2_last_ff;
   logic          s2_drain_ff;
   logic [CW-1:0] s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         s2_e1_ff <= 1'b0;
         s2_e2_ff <= 1'b0;
      end else begin
         // the incoming top row releases nothing
         s2_e1_ff <= s1_work & ~s1_c0_ff & ~s1_first_ff;
         s2_e2_ff <= s1_work & s1_last_ff & ~s1_first_ff;
      end
      s2_last_ff  <= s1_last_ff;
      s2_drain_ff <= s1_drain_ff;
      s2_col_ff   <= s1_col_ff;
   end

   // result for the previous column, then on the last column the row-end result
   logic          bin1, bin2;
   rsp_entry_type ent1, ent2;

   always_comb begin
      if (s2_last_ff) begin
         bin1 = threshold(left_ff, win_ff[0], win_ff[1]);
      end else begin
         bin1 = threshold(win_ff[0], win_ff[1], win_ff[2]);
      end
      bin2 = threshold(win_ff[0], win_ff[1], win_ff[2]);

      ent1.binary_value = bin1;
      ent1.column_index = COL_IDX_BITS'(s2_col_ff - CW'(1));
      ent1.row_end      = 1'b0;
      ent1.frame_end    = 1'b0;

      ent2.binary_value = bin2;
      ent2.column_index = COL_IDX_BITS'(s2_col_ff);
      ent2.row_end      = 1'b1;
      ent2.frame_end    = s2_drain_ff;
   end

   // ---------------------------------------------------------------------------------
   // Result queue: up to two pushes and one pop per cycle. Intake holds off while the
   // queue could not absorb everything still in flight plus one more transaction.
   // ---------------------------------------------------------------------------------
   rsp_entry_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]   head_ff, tail_ff;
   logic [FIFO_CNT_BITS-1:0]   count_ff, count_in;
   logic [1:0]                 push_n;
   logic                       pop;
   logic [NEED_BITS-1:0]       need;
   rsp_entry_type              head_ent;

   assign push_n = {1'b0, s2_e1_ff} + {1'b0, s2_e2_ff};
   assign pop    = rsp_valid & rsp_ready;

   always_comb begin
      need = NEED_BITS'(count_ff);
      if (s1_valid_ff) begin
         need = need + NEED_BITS'(2);
      end
      if (s2_e1_ff || s2_e2_ff) begin
         need = need + NEED_BITS'(2);
      end
      count_in = count_ff + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
   end

   assign req_ready = (need <= NEED_BITS'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (s2_e1_ff) begin
         fifo_ff[tail_ff] <= ent1;
      end
      if (s2_e2_ff) begin
         fifo_ff[s2_e1_ff ? tail_ff + FIFO_PTR_BITS'(1) : tail_ff] <= ent2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_ff + FIFO_PTR_BITS'(pop);
         tail_ff  <= tail_ff + FIFO_PTR_BITS'(push_n);
         count_ff <= count_in;
      end
   end

   assign head_ent         = fifo_ff[head_ff];
   assign rsp_valid        = (count_ff != '0);
   assign rsp_binary_value = head_ent.binary_value;
   assign rsp_column_index = head_ent.column_index;
   assign rsp_row_end      = head_ent.row_end;
   assign rsp_frame_end    = head_ent.frame_end;

endmodule

>>> rtl/lmb_checker.sv
module lmb_checker
   import lmb_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_binary_value,
   input logic [COL_IDX_BITS-1:0] rsp_column_index,
   input logic                    rsp_row_end,
   input logic                    rsp_frame_end
);

   // hold a stalled result transaction unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_binary_value)
         && $stable(rsp_column_index) && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("stalled result transaction changed");

   // the frame only ends on the end of a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   // reset drops every queued result
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result presented straight after reset");

   // an empty block takes input at once
   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready straight after reset");

endmodule

bind local_mean_binarize_3x3 lmb_checker u_lmb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_binary_value (rsp_binary_value),
   .rsp_column_index (rsp_column_index),
   .rsp_row_end      (rsp_row_end),
   .rsp_frame_end    (rsp_frame_end)
);

>>> dv/tb_local_mean_binarize_3x3.sv
`timescale 1ns / 100ps

module tb_local_mean_binarize_3x3
   import lmb_pkg::*;
();

   localparam int MAX_COLS        = 4096;
   localparam int WINDOW_TAPS     = 9;      // the centre is weighed against nine pixels
   localparam int RANDOM_ITEMS    = 1500;
   localparam int SETTLE_CYCLES   = 4;      // margin for the pipeline to empty
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int unsigned NO_CUT = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } req_opcode_type;

   // Predicts every result of the block and checks the results against it in order.
   class binarize_scoreboard;
      logic [7:0]               row_above  [MAX_COLS];
      logic [7:0]               row_centre [MAX_COLS];
      logic [7:0]               taps [3][3];
      logic [CFG_COLS_BITS-1:0] col_cfg;
      logic [CFG_ROWS_BITS-1:0] row_cfg;
      int unsigned              cur_row;
      int unsigned              cur_col;
      rsp_entry_type            expected_bits [$];
      int unsigned              mismatches;

      function void power_on();
         col_cfg = COLS_RESET;
         row_cfg = ROWS_RESET;
         for (int i = 0; i < MAX_COLS; i++) begin
            row_above[i]  = '0;
            row_centre[i] = '0;
         end
         mismatches = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) taps[r][k] = '0;
         end
         cur_row = 0;
         cur_col = 0;
      endfunction

      function int unsigned width_used();
         int unsigned w;
         w = 32'(col_cfg);
         if (w == 0) return 1;
         if (w > MAX_COLS) return MAX_COLS;
         return w;
      endfunction

      function int unsigned height_used();
         return (row_cfg == '0) ? 1 : 32'(row_cfg);
      endfunction

      function int unsigned outstanding();
         return expected_bits.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_COLUMN_COUNT: col_cfg = data[CFG_COLS_BITS-1:0];
            CSR_ROW_COUNT:    row_cfg = data[CFG_ROWS_BITS-1:0];
            default: ;
         endcase
         restart_frame();
      endfunction

      function void shift_taps(logic [7:0] top, logic [7:0] mid, logic [7:0] bot);
         for (int r = 0; r < 3; r++) begin
            taps[r][0] = taps[r][1];
            taps[r][1] = taps[r][2];
         end
         taps[0][2] = top;
         taps[1][2] = mid;
         taps[2][2] = bot;
      endfunction

      function void push_threshold(int unsigned col, logic rend, logic fend);
         int unsigned   total;
         int unsigned   centre_weighted;
         rsp_entry_type e;
         total = 0;
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) total += 32'(taps[r][k]);
         end
         centre_weighted  = WINDOW_TAPS * int'(taps[1][1]);
         e.binary_value   = (centre_weighted > total);
         e.column_index   = col[COL_IDX_BITS-1:0];
         e.row_end        = rend;
         e.frame_end      = fend;
         expected_bits.push_back(e);
      endfunction

      function void note_input(req_opcode_type op, logic [7:0] pixel);
         int unsigned w;
         int unsigned h;
         int unsigned c;
         logic [7:0]  top;
         logic [7:0]  mid;
         logic [7:0]  bot;
         w = width_used();
         h = height_used();
         if (cur_row > h) cur_row = h;
         if (cur_col >= w) cur_col = 0;
         c = cur_col;
         if (op == OP_DRAIN) begin
            if (cur_row != h) return;
            bot = row_centre[c];
         end else begin
            if (cur_row >= h) return;
            bot = pixel;
         end
         if (cur_row == 0) begin
            top           = bot;
            mid           = bot;
            row_above[c]  = bot;
            row_centre[c] = bot;
         end else begin
            top = row_above[c];
            mid = row_centre[c];
            if (op == OP_PIXEL) begin
               row_above[c]  = mid;
               row_centre[c] = bot;
            end
         end
         if (c == 0) begin
            repeat (3) shift_taps(top, mid, bot);
         end else begin
            shift_taps(top, mid, bot);
            if (cur_row != 0) push_threshold(c - 1, 1'b0, 1'b0);
         end
         if (c == w - 1) begin
            shift_taps(top, mid, bot);
            if (cur_row != 0) push_threshold(c, 1'b1, op == OP_DRAIN);
            cur_col = 0;
            cur_row = (op == OP_DRAIN) ? 0 : cur_row + 1;
         end else begin
            cur_col = c + 1;
         end
      endfunction

      function void check_result(rsp_entry_type got);
         rsp_entry_type exp;
         if (expected_bits.size() == 0) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: unexpected result, expected none, actual column %0d value %0b",
                        $time, got.column_index, got.binary_value);
            return;
         end
         exp = expected_bits.pop_front();
         if (got.binary_value !== exp.binary_value) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: column %0d binary_value, expected %0b, actual %0b",
                        $time, exp.column_index, exp.binary_value, got.binary_value);
         end
         if (got.column_index !== exp.column_index) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: column_index, expected %0d, actual %0d",
                        $time, exp.column_index, got.column_index);
         end
         if (got.row_end !== exp.row_end) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: column %0d row_end, expected %0b, actual %0b",
                        $time, exp.column_index, exp.row_end, got.row_end);
         end
         if (got.frame_end !== exp.frame_end) begin
            mismatches++;
            if (mismatches <= 50)
               $display("%0t: column %0d frame_end, expected %0b, actual %0b",
                        $time, exp.column_index, exp.frame_end, got.frame_end);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_opcode;
   logic [7:0]                req_pixel;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_binary_value;
   logic [COL_IDX_BITS-1:0]   rsp_column_index;
   logic                      rsp_row_end;
   logic                      rsp_frame_end;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   binarize_scoreboard sb;
   bit                 steady_tail;     // no idling on either side once set
   int unsigned        idle_pct;        // chance of a sender gap before each transaction
   int unsigned        live_items;      // transactions that the block acts on
   int unsigned        stalled_cycles;

   local_mean_binarize_3x3 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_binary_value (rsp_binary_value),
      .rsp_column_index (rsp_column_index),
      .rsp_row_end      (rsp_row_end),
      .rsp_frame_end    (rsp_frame_end),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Result side: hold ready high for stretches of varying length, and drop it between
   // them until the steady tail of the run.
   initial begin : rsp_side
      int unsigned stretch;
      rsp_ready = 1'b0;
      forever begin
         stretch = ($urandom_range(3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
         rsp_ready = 1'b1;
         repeat (stretch) @(negedge clock);
         if (!steady_tail) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
      end
   end

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin
      rsp_entry_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.binary_value = rsp_binary_value;
         got.column_index = rsp_column_index;
         got.row_end      = rsp_row_end;
         got.frame_end    = rsp_frame_end;
         sb.check_result(got);
      end
   end

   // Watchdog: end the run when neither channel has moved a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stalled_cycles = 0;
      else
         stalled_cycles++;
      if (stalled_cycles == WATCHDOG_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // All driver tasks start and end just after a falling edge.
   task automatic send_item(req_opcode_type op, logic [7:0] pixel);
      req_valid  = 1'b1;
      req_opcode = op;
      req_pixel  = pixel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(op, pixel);
      @(negedge clock);
   endtask

   task automatic idle_for(int unsigned cycles);
      req_valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic maybe_idle();
      if (!steady_tail && $urandom_range(99) < idle_pct) idle_for($urandom_range(1, 8));
   endtask

   task automatic hold_until_drained();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // Let the block go quiet before touching its registers: some transactions give no
   // result, so wait out the pipeline after the last expected result as well.
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(bit set_cols, logic [CSR_DATA_BITS-1:0] cols,
                            bit set_rows, logic [CSR_DATA_BITS-1:0] rows);
      settle();
      if (set_cols) write_csr(CSR_COLUMN_COUNT, cols);
      if (set_rows) write_csr(CSR_ROW_COUNT, rows);
      csr_we = 1'b0;
   endtask

   function automatic logic [7:0] pick_pixel(int unsigned style);
      case (style)
         0:       return 8'($urandom_range(0, 255));
         1:       return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
         2:       return 8'($urandom_range(120, 123));   // near-ties around a flat level
         default: return 8'($urandom_range(0, 1));
      endcase
   endfunction

   // Stream one frame in the current geometry followed by its drain row. Stop after
   // 'cut' live transactions to leave a broken frame behind. Scatter stray drain ticks
   // among the pixels and now and then a stray pixel after the last row; the block
   // must ignore both.
   task automatic run_frame(int unsigned cut, int unsigned style, bit pause_mid);
      int unsigned w;
      int unsigned h;
      int unsigned sent;
      int unsigned pause_at;
      w        = sb.width_used();
      h        = sb.height_used();
      sent     = 0;
      pause_at = pause_mid ? $urandom_range(1, w * h + w - 1) : NO_CUT;
      for (int unsigned r = 0; r < h; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if (sent == cut) return;
            if ($urandom_range(99) < 3) send_item(OP_DRAIN, 8'($urandom));
            if (sent == pause_at) hold_until_drained();
            maybe_idle();
            send_item(OP_PIXEL, pick_pixel(style));
            sent++;
            live_items++;
         end
      end
      if ($urandom_range(4) == 0) send_item(OP_PIXEL, 8'($urandom));
      for (int unsigned c = 0; c < w; c++) begin
         if (sent == cut) return;
         if (sent == pause_at) hold_until_drained();
         maybe_idle();
         send_item(OP_DRAIN, 8'($urandom));
         sent++;
         live_items++;
      end
   endtask

   initial begin
      int unsigned              frame_no;
      int unsigned              sel;
      int unsigned              cols;
      int unsigned              rows;
      logic [CSR_DATA_BITS-1:0] cols_word;
      bit                       set_cols;
      bit                       set_rows;
      bit                       pause_mid;
      int unsigned              cut;

      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_opcode  = OP_PIXEL;
      req_pixel   = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_COLUMN_COUNT;
      csr_wdata   = '0;
      steady_tail = 1'b0;
      idle_pct    = 25;
      live_items  = 0;
      sb = new;
      sb.power_on();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset geometry: stream the start of the first row of a 2048-wide frame; no
      // result may appear while that row is still coming in.
      run_frame(64, 0, 1'b0);

      // Directed: 3x2 frame with full-scale contrast, a drain tick before the last row,
      // a pixel after the last row, then the drain row closing the frame.
      configure(1'b1, 16'd3, 1'b1, 16'd2);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_DRAIN, 8'hFF);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_PIXEL, 8'h00);
      send_item(OP_PIXEL, 8'h80);
      repeat (3) send_item(OP_DRAIN, 8'h00);

      // Zero geometry acts as a single pixel: the drain gives one row and frame end.
      configure(1'b1, 16'd0, 1'b1, 16'd0);
      send_item(OP_PIXEL, 8'hFF);
      send_item(OP_DRAIN, 8'h55);

      // Flat image: nine times the centre equals the sum, so every bit is zero.
      configure(1'b1, 16'd2, 1'b1, 16'd1);
      send_item(OP_PIXEL, 8'h07);
      send_item(OP_PIXEL, 8'h07);
      send_item(OP_DRAIN, 8'hAA);
      send_item(OP_DRAIN, 8'h00);

      // Tallest frame: run a few rows only; the next write abandons it.
      configure(1'b0, 16'd0, 1'b1, 16'hFFFF);
      repeat (6) send_item(OP_PIXEL, pick_pixel(0));

      // Random frames: mostly small and well formed, some broken off part-way.
      live_items = 0;
      frame_no   = 0;
      while (live_items < RANDOM_ITEMS) begin
         steady_tail = (live_items >= RANDOM_ITEMS * 85 / 100);
         idle_pct    = (steady_tail || frame_no % 4 == 3) ? 0 : $urandom_range(10, 50);

         sel = $urandom_range(99);
         if (sel < 70)      cols = $urandom_range(1, 8);
         else if (sel < 95) cols = $urandom_range(9, 40);
         else               cols = $urandom_range(41, 130);
         if ($urandom_range(19) == 0) cols = 0;
         rows = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         if ($urandom_range(19) == 0) rows = 0;

         // Bits above the column field must be dropped by the block.
         cols_word = CSR_DATA_BITS'(cols);
         if ($urandom_range(4) == 0)
            cols_word[CSR_DATA_BITS-1:CFG_COLS_BITS] =
               (CSR_DATA_BITS - CFG_COLS_BITS)'($urandom_range(1, 7));

         sel      = $urandom_range(5);
         set_cols = (frame_no == 0) || (sel != 1);
         set_rows = (frame_no == 0) || (sel != 0);
         configure(set_cols, cols_word, set_rows, CSR_DATA_BITS'(rows));

         // The first frame always pauses the sender until every result is back.
         pause_mid = (frame_no == 0) || ($urandom_range(9) == 0);
         cut = (frame_no != 0 && $urandom_range(9) == 0) ?
               $urandom_range(0, sb.width_used() * (sb.height_used() + 1) - 1) : NO_CUT;
         run_frame(cut, $urandom_range(3), pause_mid);
         frame_no++;
      end

      steady_tail = 1'b1;
      hold_until_drained();
      repeat (8) @(negedge clock);
      if (sb.mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
